FILE: hw/rtl/prc_pkg.sv
// Shared types, constants and sequencer states of the polygon ring centroid block.
package prc_pkg;

	localparam int FIELD_W          = 16;
	localparam int LIMIT_W          = 20;
	localparam int COORD_BITS_DEF   = 16;
	localparam int MAX_VERTICES_DEF = 4096;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1;

	typedef struct packed {
		logic signed [FIELD_W-1:0] vertex_x;
		logic signed [FIELD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] centre_x;
		logic signed [FIELD_W-1:0] centre_y;
		logic                      degenerate;
		logic                      too_long;
	} centre_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CROSS,
		ST_MUL3,
		ST_MUL4,
		ST_ACC,
		ST_DECIDE,
		ST_LOAD,
		ST_DIV,
		ST_DIVEND,
		ST_OUT
	} st_t;

endpackage

FILE: hw/rtl/polygon_ring_centroid.sv
// Area-weighted centroid of a polygon ring, one shared multiplier and one shared divider.
// The first vertex of a ring opens it without an edge; each further vertex within MAX_VERTICES runs one shoelace
// edge on the shared multiplier: four products, one subtract, one accumulate.
// A last vertex adds the closing edge and two restoring divisions of MOM_W steps each;
// a last vertex that opens the ring or is dropped runs the closing edge alone, and the
// result waits in the output step while a held result is stalled.
// Reset clears the sequencer, the vertex count and the output valid; the limit resets to 1.
module polygon_ring_centroid
	import prc_pkg::*;
#(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vertex_valid,
	output logic               vertex_stall,
	input  vertex_t            vertex_data,
	output logic               centre_valid,
	input  logic               centre_stall,
	output centre_t            centre_data,
	input  logic               limit_valid,
	output logic               limit_ready,
	input  logic [LIMIT_W-1:0] limit_data
);

	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int CROSS_W = 2 * COORD_BITS + 1;
	localparam int SUMC_W  = COORD_BITS + 1;
	localparam int PROD_W  = SUMC_W + CROSS_W;
	localparam int AREA_W  = CROSS_W + CNT_W;
	localparam int MOM_W   = PROD_W + CNT_W;
	localparam int CSUM_W  = COORD_BITS + CNT_W;
	localparam int DEN_W   = AREA_W + 2;
	localparam int DCNT_W  = $clog2(MOM_W);

	st_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic               closing_q;
	logic               sel_y_q;
	logic               centre_valid_q;

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic                         last_q;
	logic                         degen_q;
	logic signed [AREA_W-1:0]     area_q;
	logic signed [MOM_W-1:0]      mx_q, my_q;
	logic signed [CSUM_W-1:0]     csx_q, csy_q;
	logic signed [CROSS_W-1:0]    cross_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic [DEN_W-1:0]             div_den_q, div_rem_q;
	logic [MOM_W-1:0]             div_quo_q;
	logic                         div_neg_q;
	logic [DCNT_W-1:0]            div_cnt_q;
	logic signed [COORD_BITS-1:0] res_x_q, res_y_q;
	centre_t                      centre_q;

	logic signed [COORD_BITS-1:0] in_x, in_y, b_x, b_y;
	logic signed [SUMC_W-1:0]     mul_a;
	logic signed [CROSS_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]     mul_p;
	logic                         room;
	logic                         out_free;
	logic [AREA_W-1:0]            area_mag;
	logic                         degen_c;
	logic signed [DEN_W-1:0]      area3;
	logic signed [MOM_W-1:0]      ld_num;
	logic signed [DEN_W-1:0]      ld_den;
	logic [MOM_W-1:0]             num_mag;
	logic [DEN_W-1:0]             den_mag;
	logic [DEN_W:0]               div_shift, div_diff;
	logic                         div_bit;
	logic [MOM_W-1:0]             sat_lim;
	logic signed [COORD_BITS-1:0] sat_v;

	assign in_x = vertex_data.vertex_x[COORD_BITS-1:0];
	assign in_y = vertex_data.vertex_y[COORD_BITS-1:0];

	// The closing edge runs from the previous vertex back to the first one.
	assign b_x = closing_q ? first_x_q : cur_x_q;
	assign b_y = closing_q ? first_y_q : cur_y_q;

	assign room     = count_q < CNT_W'(MAX_VERTICES);
	assign out_free = !centre_valid_q || !centre_stall;
	assign mul_p    = mul_a * mul_b;

	assign area_mag = area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);
	assign degen_c  = (area_q == '0) ||
		({{LIMIT_W{1'b0}}, area_mag} < {{AREA_W{1'b0}}, limit_q});

	assign area3  = DEN_W'(area_q) + (DEN_W'(area_q) <<< 1);
	assign ld_num = degen_q ? (sel_y_q ? MOM_W'(csy_q) : MOM_W'(csx_q))
		: (sel_y_q ? my_q : mx_q);
	assign ld_den = degen_q ? DEN_W'(count_q) : area3;
	assign num_mag = ld_num[MOM_W-1] ? MOM_W'(-ld_num) : MOM_W'(ld_num);
	assign den_mag = ld_den[DEN_W-1] ? DEN_W'(-ld_den) : DEN_W'(ld_den);

	// One restoring division step: shift in the next dividend bit and try the subtract.
	assign div_shift = {div_rem_q, div_quo_q[MOM_W-1]};
	assign div_diff  = div_shift - {1'b0, div_den_q};
	assign div_bit   = !div_diff[DEN_W];

	assign sat_lim = MOM_W'(1) << (COORD_BITS - 1);

	always_comb begin
		if (div_neg_q) begin
			if (div_quo_q > sat_lim) begin
				sat_v = {1'b1, {(COORD_BITS-1){1'b0}}};
			end else begin
				sat_v = '0 - div_quo_q[COORD_BITS-1:0];
			end
		end else begin
			if (div_quo_q >= sat_lim) begin
				sat_v = {1'b0, {(COORD_BITS-1){1'b1}}};
			end else begin
				sat_v = div_quo_q[COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (vertex_valid) begin
					if (count_q != '0 && room) begin
						state_d = ST_MUL1;
					end else if (vertex_data.last_vertex) begin
						state_d = ST_MUL1;
					end
				end
			end
			ST_MUL1: begin
				mul_a   = SUMC_W'(prev_x_q);
				mul_b   = CROSS_W'(b_y);
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				mul_a   = SUMC_W'(b_x);
				mul_b   = CROSS_W'(prev_y_q);
				state_d = ST_CROSS;
			end
			ST_CROSS: begin
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				mul_a   = SUMC_W'(prev_x_q) + SUMC_W'(b_x);
				mul_b   = cross_q;
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				mul_a   = SUMC_W'(prev_y_q) + SUMC_W'(b_y);
				mul_b   = cross_q;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (closing_q) begin
					state_d = ST_DECIDE;
				end else if (last_q) begin
					state_d = ST_MUL1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_DIVEND;
				end
			end
			ST_DIVEND: begin
				state_d = sel_y_q ? ST_OUT : ST_LOAD;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= LIMIT_RESET;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			closing_q      <= 1'b0;
			sel_y_q        <= 1'b0;
			centre_valid_q <= 1'b0;
		end else begin
			if (limit_valid) begin
				limit_q <= limit_data;
			end
			// A held result leaves when taken; the output step raises the next one.
			if (state_q == ST_OUT && out_free) begin
				centre_valid_q <= 1'b1;
			end else if (!centre_stall) begin
				centre_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (vertex_valid) begin
						closing_q <= (count_q == '0) || !room;
						if (count_q == '0) begin
							count_q <= CNT_W'(1);
							ovf_q   <= 1'b0;
						end else if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_ACC: begin
					closing_q <= 1'b1;
				end
				ST_DECIDE: begin
					sel_y_q <= 1'b0;
				end
				ST_DIVEND: begin
					sel_y_q <= 1'b1;
				end
				ST_OUT: begin
					if (out_free) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (vertex_valid) begin
					cur_x_q <= in_x;
					cur_y_q <= in_y;
					last_q  <= vertex_data.last_vertex;
					if (count_q == '0) begin
						first_x_q <= in_x;
						first_y_q <= in_y;
						prev_x_q  <= in_x;
						prev_y_q  <= in_y;
						area_q    <= '0;
						mx_q      <= '0;
						my_q      <= '0;
						csx_q     <= CSUM_W'(in_x);
						csy_q     <= CSUM_W'(in_y);
					end else if (room) begin
						csx_q <= csx_q + CSUM_W'(in_x);
						csy_q <= csy_q + CSUM_W'(in_y);
					end
				end
			end
			ST_MUL1: begin
				prod_q <= mul_p;
			end
			ST_MUL2: begin
				prod_q  <= mul_p;
				cross_q <= CROSS_W'(prod_q);
			end
			ST_CROSS: begin
				cross_q <= cross_q - CROSS_W'(prod_q);
			end
			ST_MUL3: begin
				prod_q <= mul_p;
				area_q <= area_q + AREA_W'(cross_q);
			end
			ST_MUL4: begin
				prod_q <= mul_p;
				mx_q   <= mx_q + MOM_W'(prod_q);
			end
			ST_ACC: begin
				my_q <= my_q + MOM_W'(prod_q);
				if (!closing_q) begin
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
				end
			end
			ST_DECIDE: begin
				degen_q <= degen_c;
			end
			ST_LOAD: begin
				div_den_q <= den_mag;
				div_quo_q <= num_mag;
				div_rem_q <= '0;
				div_neg_q <= ld_num[MOM_W-1] ^ ld_den[DEN_W-1];
				div_cnt_q <= DCNT_W'(MOM_W - 1);
			end
			ST_DIV: begin
				div_rem_q <= div_bit ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
				div_quo_q <= {div_quo_q[MOM_W-2:0], div_bit};
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			ST_DIVEND: begin
				if (sel_y_q) begin
					res_y_q <= sat_v;
				end else begin
					res_x_q <= sat_v;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					centre_q.centre_x   <= FIELD_W'(res_x_q);
					centre_q.centre_y   <= FIELD_W'(res_y_q);
					centre_q.degenerate <= degen_q;
					centre_q.too_long   <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign vertex_stall = (state_q != ST_IDLE);
	assign centre_valid = centre_valid_q;
	assign centre_data  = centre_q;
	assign limit_ready  = 1'b1;

	// A new result is only ever raised by the output step of the sequencer.
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(centre_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond the ring limit");

	a_overflow_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_stall && count_q == CNT_W'(MAX_VERTICES) |=> ovf_q)
		else $error("extra vertex did not mark the ring as too long");

	a_decide_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> closing_q)
		else $error("division started before the closing edge");

	// The divisor is never zero, so the partial remainder stays below it.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_rem_q < div_den_q)
		else $error("divider remainder out of range");

endmodule

FILE: bench/centroid_checker.sv
// Channel monitor and shoelace centroid predictor that scores every centroid the block emits.
`timescale 1ns / 100ps
module centroid_checker
	import prc_pkg::*;
#(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vertex_valid,
	input  logic               vertex_stall,
	input  vertex_t            vertex_data,
	input  logic               centre_valid,
	input  logic               centre_stall,
	input  centre_t            centre_data,
	input  logic               limit_valid,
	input  logic               limit_ready,
	input  logic [LIMIT_W-1:0] limit_data,
	output int                 failures,
	output int                 pending
);

	longint first_x, first_y, prev_x, prev_y;
	longint twice_area, moment_x, moment_y, sum_x, sum_y;
	int unsigned ring_len;
	bit truncated;
	logic [LIMIT_W-1:0] area_limit;
	centre_t expected_centres[$];
	int mismatch_count;

	function automatic longint coord_of(input logic [FIELD_W-1:0] raw);
		longint v;
		v = longint'({48'd0, raw}) & ((64'sd1 << COORD_BITS) - 1);
		if (v[COORD_BITS-1]) begin
			v = v - (64'sd1 << COORD_BITS);
		end
		return v;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_coord(input longint v);
		longint hi, lo, s;
		hi = (64'sd1 << (COORD_BITS - 1)) - 1;
		lo = -(64'sd1 << (COORD_BITS - 1));
		s = (v > hi) ? hi : ((v < lo) ? lo : v);
		return s[FIELD_W-1:0];
	endfunction

	function automatic void add_edge(input longint ax, ay, bx, by);
		longint cross_term;
		cross_term = ax * by - bx * ay;
		twice_area += cross_term;
		moment_x += (ax + bx) * cross_term;
		moment_y += (ay + by) * cross_term;
	endfunction

	function automatic void clear_ring();
		ring_len = 0;
		truncated = 0;
		twice_area = 0;
		moment_x = 0;
		moment_y = 0;
		sum_x = 0;
		sum_y = 0;
	endfunction

	// Folds one accepted vertex into the ring; returns 1 with the centroid when the ring closes.
	function automatic bit predict_vertex(input vertex_t v, output centre_t c);
		longint x, y, mag, cx, cy;
		bit degen;
		x = coord_of(v.vertex_x);
		y = coord_of(v.vertex_y);
		c = '0;
		if (ring_len == 0) begin
			clear_ring();
			first_x = x;
			first_y = y;
			prev_x = x;
			prev_y = y;
			sum_x = x;
			sum_y = y;
			ring_len = 1;
		end else if (ring_len < MAX_VERTICES) begin
			add_edge(prev_x, prev_y, x, y);
			sum_x += x;
			sum_y += y;
			prev_x = x;
			prev_y = y;
			ring_len++;
		end else begin
			truncated = 1;
		end
		if (!v.last_vertex) begin
			return 0;
		end
		add_edge(prev_x, prev_y, first_x, first_y);
		mag = (twice_area < 0) ? -twice_area : twice_area;
		// A zero area falls back to the vertex average even with a zero limit.
		degen = (twice_area == 0) || (mag < longint'({44'd0, area_limit}));
		if (degen) begin
			cx = sum_x / longint'(ring_len);
			cy = sum_y / longint'(ring_len);
		end else begin
			cx = moment_x / (3 * twice_area);
			cy = moment_y / (3 * twice_area);
		end
		c.centre_x = clamp_coord(cx);
		c.centre_y = clamp_coord(cy);
		c.degenerate = degen;
		c.too_long = truncated;
		clear_ring();
		return 1;
	endfunction

	function automatic void compare_field(input string name, input longint want, got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		centre_t want, got;
		if (!arst_n) begin
			first_x = 0;
			first_y = 0;
			prev_x = 0;
			prev_y = 0;
			clear_ring();
			area_limit = LIMIT_RESET;
			expected_centres.delete();
			mismatch_count = 0;
		end else begin
			if (limit_valid && limit_ready) begin
				area_limit = limit_data;
			end
			if (vertex_valid && !vertex_stall) begin
				if (predict_vertex(vertex_data, want)) begin
					expected_centres = {expected_centres, want};
				end
			end
			if (centre_valid && !centre_stall) begin
				got = centre_data;
				if (expected_centres.size() == 0) begin
					$display("%0t: centroid expected none actual %0d,%0d", $time,
						got.centre_x, got.centre_y);
					mismatch_count++;
				end else begin
					want = expected_centres.pop_front();
					compare_field("centre_x", longint'(want.centre_x), longint'(got.centre_x));
					compare_field("centre_y", longint'(want.centre_y), longint'(got.centre_y));
					compare_field("degenerate", longint'(want.degenerate),
						longint'(got.degenerate));
					compare_field("too_long", longint'(want.too_long), longint'(got.too_long));
				end
			end
		end
		failures <= mismatch_count;
		pending <= expected_centres.size();
	end

endmodule

FILE: bench/tb_top.sv
// Stimulus and verdict for the polygon ring centroid block, scored by centroid_checker.
`timescale 1ns / 100ps
module tb_top
	import prc_pkg::*;
();

	typedef enum int {
		SHAPE_WIDE,
		SHAPE_TIGHT,
		SHAPE_LINE,
		SHAPE_SAME
	} shape_t;

	localparam int RANDOM_VERTICES = 1220;
	localparam int PHASE_VERTICES  = 250;
	localparam int SETTLE_CYCLES   = 200;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               vertex_valid = 1'b0;
	logic               vertex_stall;
	vertex_t            vertex_data = '0;
	logic               centre_valid;
	logic               centre_stall = 1'b0;
	centre_t            centre_data;
	logic               limit_valid = 1'b0;
	logic               limit_ready;
	logic [LIMIT_W-1:0] limit_data = '0;

	int failures;
	int pending;
	bit calm = 1'b0;
	int rx_left = 0;
	int rx_gap;
	int sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	polygon_ring_centroid dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex_data (vertex_data),
		.centre_valid(centre_valid),
		.centre_stall(centre_stall),
		.centre_data (centre_data),
		.limit_valid (limit_valid),
		.limit_ready (limit_ready),
		.limit_data  (limit_data)
	);

	centroid_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.vertex_data (vertex_data),
		.centre_valid(centre_valid),
		.centre_stall(centre_stall),
		.centre_data (centre_data),
		.limit_valid (limit_valid),
		.limit_ready (limit_ready),
		.limit_data  (limit_data),
		.failures    (failures),
		.pending     (pending)
	);

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// The stall for each centroid only counts down while that centroid is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_stall <= 1'b0;
			rx_left <= 0;
		end else if (centre_valid && !centre_stall) begin
			rx_gap = draw_gap();
			rx_left <= rx_gap;
			centre_stall <= (rx_gap != 0);
		end else if (centre_valid && rx_left > 0) begin
			rx_left <= rx_left - 1;
			centre_stall <= (rx_left > 1);
		end
	end

	task automatic send_vertex(input int x, y, input bit last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_valid <= 1'b1;
		vertex_data <= '{vertex_x: 16'(x), vertex_y: 16'(y), last_vertex: last};
		do @(posedge clk); while (vertex_stall);
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
	endtask

	// The limit only changes once every centroid is out and the block has gone quiet.
	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		vertex_valid <= 1'b0;
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		limit_valid <= 1'b1;
		limit_data <= value;
		do @(posedge clk); while (!limit_ready);
		limit_valid <= 1'b0;
	endtask

	task automatic send_ring(input int len, input shape_t shape);
		int bx, by, dx, dy, x, y;
		bx = int'($urandom_range(0, 60000)) - 30000;
		by = int'($urandom_range(0, 60000)) - 30000;
		dx = int'($urandom_range(0, 40)) - 20;
		dy = int'($urandom_range(0, 40)) - 20;
		if (shape == SHAPE_LINE) begin
			bx = bx / 30;
			by = by / 30;
		end
		for (int k = 0; k < len; k++) begin
			case (shape)
				SHAPE_WIDE: begin
					x = int'($urandom);
					y = int'($urandom);
				end
				SHAPE_TIGHT: begin
					x = bx + int'($urandom_range(0, 80)) - 40;
					y = by + int'($urandom_range(0, 80)) - 40;
				end
				SHAPE_LINE: begin
					x = bx + k * dx;
					y = by + k * dy;
				end
				default: begin
					x = bx;
					y = by;
				end
			endcase
			send_vertex(x, y, k == len - 1);
		end
	endtask

	initial begin
		int next_phase, phase, pick, len;
		shape_t shape;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rings, first under the limit left by reset.
		send_vertex(32767, -32768, 1);
		send_vertex(-32768, 32767, 1);
		send_vertex(-3, 0, 0);
		send_vertex(0, -4, 1);
		send_vertex(-32768, -32768, 0);
		send_vertex(32767, -32768, 0);
		send_vertex(32767, 32767, 1);
		send_vertex(32767, 32767, 0);
		send_vertex(32767, -32768, 0);
		send_vertex(-32768, -32768, 1);
		send_vertex(0, 0, 0);
		send_vertex(1, 0, 0);
		send_vertex(0, 1, 1);
		send_vertex(-32768, -32768, 0);
		send_vertex(32767, 32767, 0);
		send_vertex(32767, -32768, 0);
		send_vertex(-32767, 32767, 1);

		set_limit('0);
		send_vertex(0, 0, 0);
		send_vertex(5, 5, 0);
		send_vertex(10, 10, 1);
		send_vertex(0, 0, 0);
		send_vertex(1, 0, 0);
		send_vertex(0, 1, 1);

		set_limit('1);
		send_vertex(-100, -100, 0);
		send_vertex(100, -100, 0);
		send_vertex(100, 100, 0);
		send_vertex(-100, 100, 1);

		next_phase = 0;
		phase = 0;
		while (sent < RANDOM_VERTICES) begin
			if (sent >= next_phase) begin
				case (phase % 5)
					0: set_limit('0);
					1: set_limit('1);
					2: set_limit(LIMIT_W'($urandom_range(0, 4000)));
					3: set_limit(LIMIT_W'($urandom));
					default: set_limit(LIMIT_RESET);
				endcase
				phase++;
				next_phase += PHASE_VERTICES;
			end
			if ($urandom_range(0, 7) == 0) begin
				calm = !calm;
			end
			pick = $urandom_range(0, 9);
			shape = (pick < 5) ? SHAPE_WIDE : (pick < 7) ? SHAPE_TIGHT :
				(pick < 9) ? SHAPE_LINE : SHAPE_SAME;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_ring(len, shape);
			sent += len;
		end

		vertex_valid <= 1'b0;
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
